/* rtl/fsla_pkg.sv */
package fsla_pkg;

  // pool geometry
  localparam int MAX_BLOCKS           = 8;
  localparam int MAX_CHUNKS_PER_BLOCK = 64;
  localparam int HEADER_BYTES         = 8;
  localparam int POOL_SLOTS           = MAX_BLOCKS * MAX_CHUNKS_PER_BLOCK;

  // field widths
  localparam int SLOT_W   = 9;
  localparam int LINK_W   = 10;
  localparam int BLK_W    = 4;
  localparam int NCH_W    = 7;
  localparam int IDX_W    = 6;
  localparam int CHUNK_W  = 13;
  localparam int STRIDE_W = 14;
  localparam int OFS_W    = 22;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DW    = 13;

  localparam logic [LINK_W-1:0] EMPTY_LINK = LINK_W'(POOL_SLOTS);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CHUNKS_PER_BLOCK = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_SIZE       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RESIZE_ALLOWED   = 2'd2;

  typedef enum logic [1:0] {
    ST_ALLOCATED = 2'd0,
    ST_EXHAUSTED = 2'd1,
    ST_FREED     = 2'd2,
    ST_INVALID   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_GROW,
    S_RESP
  } state_t;

  typedef struct packed {
    logic [NCH_W-1:0]   chunks_per_block;
    logic [CHUNK_W-1:0] chunk_size;
    logic               resize_allowed;
  } cfg_t;

  typedef struct packed {
    status_t            status;
    logic [SLOT_W-1:0]  slot;
    logic [OFS_W-1:0]   offset;
  } res_t;

  // chunks per block clamped to 1..MAX_CHUNKS_PER_BLOCK
  function automatic logic [NCH_W-1:0] eff_chunks(input logic [NCH_W-1:0] c);
    logic [NCH_W-1:0] n;
    n = c;
    if (c == '0) n = NCH_W'(1);
    else if (c > NCH_W'(MAX_CHUNKS_PER_BLOCK)) n = NCH_W'(MAX_CHUNKS_PER_BLOCK);
    return n;
  endfunction

  // payload offset: slot * (chunk_size + header) + header, masked
  function automatic logic [OFS_W-1:0] slot_offset(input logic [SLOT_W-1:0] s,
                                                   input logic [CHUNK_W-1:0] csize);
    logic [STRIDE_W-1:0]        stride;
    logic [SLOT_W+STRIDE_W-1:0] prod;
    stride = {1'b0, csize} + STRIDE_W'(HEADER_BYTES);
    prod   = {{STRIDE_W{1'b0}}, s} * {{SLOT_W{1'b0}}, stride};
    prod   = prod + (SLOT_W+STRIDE_W)'(HEADER_BYTES);
    return prod[OFS_W-1:0];
  endfunction

endpackage

/* rtl/fsla_ram.sv */
module fsla_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // single port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

/* rtl/fsla_ctrl.sv */
module fsla_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  fsla_pkg::cfg_t        cfg,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_mode,
  input  logic [8:0]            in_slot,
  output logic                  res_valid,
  output fsla_pkg::res_t        res,
  input  logic                  res_take
);
  import fsla_pkg::*;

  state_t              state_r, state_nxt;
  logic [LINK_W-1:0]   head_r, head_nxt;
  logic [LINK_W-1:0]   slots_r, slots_nxt;
  logic [BLK_W-1:0]    blocks_r, blocks_nxt;
  logic [IDX_W-1:0]    cnt_r, cnt_nxt;
  res_t                pend_r, pend_nxt;

  logic                ram_we;
  logic [SLOT_W-1:0]   ram_addr;
  logic [LINK_W-1:0]   ram_wdata;
  logic [LINK_W-1:0]   ram_rdata;

  logic [NCH_W-1:0]    n_eff;
  logic                can_grow;
  logic                grow_last;
  logic [LINK_W-1:0]   grow_slot;
  logic                fin;
  res_t                new_res;

  // link memory
  fsla_ram #(.WIDTH(LINK_W), .DEPTH(POOL_SLOTS)) u_link_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // growth checks
  assign n_eff     = eff_chunks(cfg.chunks_per_block);
  assign can_grow  = (blocks_r < BLK_W'(MAX_BLOCKS)) &&
                     (({1'b0, slots_r} + (LINK_W+1)'(n_eff)) <= (LINK_W+1)'(POOL_SLOTS));
  assign grow_last = ({1'b0, cnt_r} + NCH_W'(1)) == n_eff;
  assign grow_slot = slots_r + LINK_W'(cnt_r);

  // next state and outputs
  always_comb begin
    state_nxt  = state_r;
    head_nxt   = head_r;
    slots_nxt  = slots_r;
    blocks_nxt = blocks_r;
    cnt_nxt    = cnt_r;
    pend_nxt   = pend_r;
    ram_we     = 1'b0;
    ram_addr   = head_r[SLOT_W-1:0];
    ram_wdata  = head_r;
    in_ready   = 1'b0;
    res_valid  = 1'b0;
    res        = pend_r;
    fin        = 1'b0;
    new_res    = '{status: ST_EXHAUSTED, slot: '0, offset: '0};

    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_mode) begin
            fin = 1'b1;
            if ({1'b0, in_slot} < slots_r) begin
              // push onto the head
              ram_we    = 1'b1;
              ram_addr  = in_slot;
              ram_wdata = head_r;
              head_nxt  = {1'b0, in_slot};
              new_res.status = ST_FREED;
            end else begin
              new_res.status = ST_INVALID;
            end
          end else if (head_r < slots_r) begin
            // fetch the link of the head
            ram_addr  = head_r[SLOT_W-1:0];
            state_nxt = S_READ;
          end else if ((blocks_r == '0 || cfg.resize_allowed) && can_grow) begin
            cnt_nxt   = '0;
            state_nxt = S_GROW;
          end else begin
            fin = 1'b1;
            new_res.status = ST_EXHAUSTED;
          end
        end
      end

      S_READ: begin
        head_nxt       = ram_rdata;
        fin            = 1'b1;
        new_res.status = ST_ALLOCATED;
        new_res.slot   = head_r[SLOT_W-1:0];
        new_res.offset = slot_offset(head_r[SLOT_W-1:0], cfg.chunk_size);
      end

      S_GROW: begin
        // link the new block in ascending order, one entry a cycle
        ram_we    = 1'b1;
        ram_addr  = grow_slot[SLOT_W-1:0];
        ram_wdata = grow_last ? EMPTY_LINK : grow_slot + LINK_W'(1);
        cnt_nxt   = cnt_r + IDX_W'(1);
        if (grow_last) begin
          slots_nxt      = slots_r + LINK_W'(n_eff);
          blocks_nxt     = blocks_r + BLK_W'(1);
          head_nxt       = (n_eff > NCH_W'(1)) ? slots_r + LINK_W'(1) : EMPTY_LINK;
          fin            = 1'b1;
          new_res.status = ST_ALLOCATED;
          new_res.slot   = slots_r[SLOT_W-1:0];
          new_res.offset = slot_offset(slots_r[SLOT_W-1:0], cfg.chunk_size);
        end
      end

      S_RESP: begin
        res_valid = 1'b1;
        res       = pend_r;
        if (res_take) state_nxt = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // hand result to the output stage, or hold it while that stage is full
    if (fin) begin
      res_valid = 1'b1;
      res       = new_res;
      if (res_take) begin
        state_nxt = S_IDLE;
      end else begin
        pend_nxt  = new_res;
        state_nxt = S_RESP;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      head_r   <= EMPTY_LINK;
      slots_r  <= '0;
      blocks_r <= '0;
      cnt_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      head_r   <= head_nxt;
      slots_r  <= slots_nxt;
      blocks_r <= blocks_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // held result
  always_ff @(posedge clk) begin
    pend_r <= pend_nxt;
  end

endmodule

/* rtl/fixed_slot_free_list_allocator.sv */
// Fixed-slot free-list allocator.
// Input channel (in_valid/in_ready): in_mode 0 allocates a slot, 1 frees in_slot.
// Result channel (out_valid/out_ready): one transaction per input, carrying
// out_status, out_granted_slot and out_byte_offset of the granted chunk.
// Configuration (cfg_we/cfg_index/cfg_wdata): chunks_per_block, chunk_size and
// resize_allowed; write only while the block is idle.
// A free is done in the idle state; an allocate from the free list reads the
// link memory at the head in the read state; an allocate that grows the pool
// writes n new links in the grow state, n being chunks_per_block clamped to
// 1..64 (one link memory write per new slot).
// Items are handled one at a time; in_ready is high while the controller is idle,
// so the input takes a new item only once the last one is finished.
// The output register lets the next item start while a result waits; if the
// receiver keeps stalling, a second finished result is held inside and the
// input stays blocked until the output register drains.
// Reset empties the pool (no blocks grown) and loads the configuration with
// 64 chunks per block, 64-byte chunks and growth allowed; the link memory
// needs no clearing.
module fixed_slot_free_list_allocator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_mode,
  input  logic [8:0]  in_slot,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [8:0]  out_granted_slot,
  output logic [21:0] out_byte_offset,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_wdata
);
  import fsla_pkg::*;

  cfg_t  cfg_r;
  logic  res_valid;
  res_t  res;
  logic  res_take;
  logic  out_valid_r;
  res_t  out_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.chunks_per_block <= NCH_W'(64);
      cfg_r.chunk_size       <= CHUNK_W'(64);
      cfg_r.resize_allowed   <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CHUNKS_PER_BLOCK: cfg_r.chunks_per_block <= cfg_wdata[NCH_W-1:0];
        CFG_CHUNK_SIZE:       cfg_r.chunk_size       <= cfg_wdata[CHUNK_W-1:0];
        CFG_RESIZE_ALLOWED:   cfg_r.resize_allowed   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  fsla_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_mode   (in_mode),
    .in_slot   (in_slot),
    .res_valid (res_valid),
    .res       (res),
    .res_take  (res_take)
  );

  // output register
  assign res_take = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take && res_valid) begin
      out_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_r.status;
  assign out_granted_slot = out_r.slot;
  assign out_byte_offset  = out_r.offset;

endmodule
